FILE: sv/ultrasonic_range_trimmed_mean_top_assert.svh
// Assertion macros for the ultrasonic ranger with trimmed mean.
// Included by the top level; needs no package.
`ifndef ULTRASONIC_RANGE_TRIMMED_MEAN_TOP_ASSERT_SVH
`define ULTRASONIC_RANGE_TRIMMED_MEAN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Condition implies property in the same cycle.
`define URTM_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("urtm assertion failed");
// Condition implies property in the next cycle.
`define URTM_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("urtm assertion failed");
`else
`define URTM_ASSERT_SAME(label, clk, rst, cond, prop)
`define URTM_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

FILE: sv/urtm_pkg.sv
// Shared types and constants of the ultrasonic ranger with trimmed mean.
// No dependencies.
package urtm_pkg;

   localparam int TICK_W = 16;
   localparam int TRIG_W = 8;
   localparam int CM_W = 11;
   localparam int REM_W = 6;
   localparam int SUM_W = 15;
   localparam int DIST_W = 15;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   // Echo width kept as centimetres plus remainder modulo 58
   localparam logic [REM_W-1:0] REM_LAST = 6'd57;
   // 65535 ticks = 1129 * 58 + 53
   localparam logic [CM_W-1:0] CM_SAT = 11'd1129;
   localparam logic [REM_W-1:0] REM_SAT = 6'd53;

   // Reciprocal division of the trimmed sum
   localparam int MEAN_SHIFT = 24;
   localparam int RECIP_W = 25;
   localparam int NUM_W = SUM_W + 4;
   localparam int PROD_W = NUM_W + RECIP_W;
   localparam int QUO_W = PROD_W - MEAN_SHIFT;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS = 1'd1;

   localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd10;
   localparam logic [TICK_W-1:0] GAP_TICKS_RST = 16'd50000;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TRIG,
      PH_WAIT,
      PH_MEAS,
      PH_GAP,
      PH_GAPL
   } phase_type;

   typedef struct packed {
      logic start_req;
      logic echo;
   } req_item_type;

   typedef struct packed {
      logic              trigger_out;
      logic              busy_res;
      logic              done_res;
      logic [DIST_W-1:0] distance_x16;
   } rsp_item_type;

   typedef struct packed {
      logic [TRIG_W-1:0] trigger_ticks;
      logic [TICK_W-1:0] gap_ticks;
   } cfg_type;

endpackage

FILE: sv/urtm_mean.sv
// Trimmed mean: (sum - min - max) * 16 / (SAMPLES - 2) by reciprocal multiply.
// Depends on urtm_pkg.
module urtm_mean
   import urtm_pkg::*;
#(
   parameter int SAMPLES = 5
) (
   input  logic [SUM_W-1:0]  sum,
   input  logic [CM_W-1:0]   min_cm,
   input  logic [CM_W-1:0]   max_cm,
   output logic [DIST_W-1:0] mean_x16
);

   localparam int MEAN_DIV = (SAMPLES > 2) ? SAMPLES - 2 : 1;
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(MEAN_DIV) - 64'd1) / 64'(MEAN_DIV));

   logic [CM_W:0]       drop;
   logic [SUM_W-1:0]    rest;
   logic [NUM_W-1:0]    num;
   logic [PROD_W-1:0]   prod;
   logic [QUO_W-1:0]    quo;

   assign drop = {1'b0, min_cm} + {1'b0, max_cm};
   assign rest = (sum >= SUM_W'(drop)) ? sum - SUM_W'(drop) : '0;
   assign num  = {rest, 4'b0000};
   assign prod = PROD_W'(num) * PROD_W'(MEAN_RECIP);
   assign quo  = prod[PROD_W-1:MEAN_SHIFT];
   // clamp to the output range
   assign mean_x16 = (quo > QUO_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : quo[DIST_W-1:0];

endmodule

FILE: sv/urtm_core.sv
// Ranging sequencer: trigger, echo timing, per-set statistics and result.
// Depends on urtm_pkg and urtm_mean.
module urtm_core
   import urtm_pkg::*;
#(
   parameter int SAMPLES = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   localparam int IDX_W = $clog2(SAMPLES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [CM_W-1:0]   cm_ff, cm_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CM_W-1:0]   min_ff, min_in;
   logic [CM_W-1:0]   max_ff, max_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              done;
   logic [DIST_W-1:0] mean_x16;

   urtm_mean #(
      .SAMPLES(SAMPLES)
   ) u_mean (
      .sum      (sum_ff),
      .min_cm   (min_ff),
      .max_cm   (max_ff),
      .mean_x16 (mean_x16)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         cm_ff    <= '0;
         rem_ff   <= '0;
         index_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         dist_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         cm_ff    <= cm_in;
         rem_ff   <= rem_in;
         index_ff <= index_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         dist_ff  <= dist_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      cm_in    = cm_ff;
      rem_in   = rem_ff;
      index_in = index_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      dist_in  = dist_ff;
      done     = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (item.start_req) begin
               index_in = '0;
               sum_in   = '0;
               min_in   = '1;
               max_in   = '0;
               cm_in    = '0;
               rem_in   = '0;
               phase_in = PH_TRIG;
               tick_in  = TICK_W'(1);
            end
         end
         PH_TRIG: begin
            if (tick_ff >= TICK_W'(cfg.trigger_ticks)) begin
               phase_in = PH_WAIT;
               tick_in  = '0;
            end else begin
               tick_in = tick_ff + TICK_W'(1);
            end
         end
         PH_WAIT: begin
            if (item.echo) begin
               phase_in = PH_MEAS;
               cm_in    = '0;
               rem_in   = REM_W'(1);
            end
         end
         PH_MEAS: begin
            if (item.echo) begin
               // hold at saturation
               if (!(cm_ff == CM_SAT && rem_ff == REM_SAT)) begin
                  if (rem_ff == REM_LAST) begin
                     rem_in = '0;
                     cm_in  = cm_ff + CM_W'(1);
                  end else begin
                     rem_in = rem_ff + REM_W'(1);
                  end
               end
            end else begin
               sum_in  = sum_ff + SUM_W'(cm_ff);
               min_in  = (cm_ff < min_ff) ? cm_ff : min_ff;
               max_in  = (cm_ff > max_ff) ? cm_ff : max_ff;
               tick_in = '0;
               if (index_ff == IDX_LAST) begin
                  index_in = '0;
                  phase_in = PH_GAPL;
               end else begin
                  index_in = index_ff + IDX_W'(1);
                  phase_in = PH_GAP;
               end
            end
         end
         PH_GAP, PH_GAPL: begin
            if (tick_ff >= cfg.gap_ticks) begin
               if (phase_ff == PH_GAPL) begin
                  dist_in  = mean_x16;
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_TRIG;
                  tick_in  = TICK_W'(1);
               end
            end else begin
               tick_in = tick_ff + TICK_W'(1);
            end
         end
         default: begin
            phase_in = PH_IDLE;
            tick_in  = '0;
         end
      endcase
   end

   assign result.trigger_out  = (phase_in == PH_TRIG);
   assign result.busy_res     = (phase_in != PH_IDLE);
   assign result.done_res     = done;
   assign result.distance_x16 = dist_in;

endmodule

FILE: sv/ultrasonic_range_trimmed_mean_top.sv
// Top level of the ultrasonic ranger with trimmed mean: handshake stages and CSRs.
// Depends on urtm_pkg, urtm_core and the assertion macro header.
`include "ultrasonic_range_trimmed_mean_top_assert.svh"

// Each input item is one microsecond tick: a start request and the sampled echo
// level. Every accepted item gives exactly one result item, in order: the trigger
// pin level, busy, a one-tick done flag and the held trimmed-mean distance in
// centimetres with 4 fraction bits. A start while idle runs SAMPLES readings
// (trigger pulse, echo width timed in ticks, converted to cm by a running
// modulo-58 counter, then a pause of gap_ticks); after the last pause the lowest
// and highest readings are dropped and the rest averaged by a reciprocal
// multiply. Waits for the echo have no timeout. The block takes one item per
// clock while rsp_ready keeps the result slot free: an input register and a
// result register each hold one item, so a new item goes in while the previous
// result waits. An accepted item moves from the input register to the result
// register, shown on rsp_valid, when that is free or being emptied. The state
// update sits between the two registers and is set by the mean's reciprocal multiply.
// Write the CSRs only while no item is in flight; writes are registered before use.
// There are no memories and no clearing pass after reset.
module ultrasonic_range_trimmed_mean_top
   import urtm_pkg::*;
#(
   parameter int SAMPLES = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_item,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   cfg_type      cfg_ff, cfg_in;
   logic         req_accept;
   logic         advance;
   rsp_item_type result;

   // Move the held item through the sequencer when the result slot is free or being emptied
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Decode CSR writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRIGGER_TICKS: cfg_in.trigger_ticks = csr_wdata[TRIG_W-1:0];
            CSR_GAP_TICKS:     cfg_in.gap_ticks     = csr_wdata[TICK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         cfg_ff.trigger_ticks <= TRIGGER_TICKS_RST;
         cfg_ff.gap_ticks     <= GAP_TICKS_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers: capture on accept and on advance only
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   urtm_core #(
      .SAMPLES(SAMPLES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `URTM_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff)
   `URTM_ASSERT_NEXT(a_held_item_stays, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_item_ff))
   `URTM_ASSERT_SAME(a_done_means_idle, clock, reset, rsp_valid_ff && rsp_item_ff.done_res, !rsp_item_ff.busy_res)
   `URTM_ASSERT_SAME(a_trigger_means_busy, clock, reset, rsp_valid_ff && rsp_item_ff.trigger_out, rsp_item_ff.busy_res)

endmodule

FILE: verif/tb_ultrasonic_range_trimmed_mean_top.sv
// Self-checking testbench for ultrasonic_range_trimmed_mean_top: a cycle-level
// tracker of the ranger predicts every result item, checked in order.
// Depends on urtm_pkg and the RTL of the top level.
module tb_ultrasonic_range_trimmed_mean_top;
   import urtm_pkg::*;

   localparam int SET_SIZE    = 5;
   localparam int QUIET_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_item;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ultrasonic_range_trimmed_mean_top #(
      .SAMPLES(SET_SIZE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Tracks the ranger tick by tick and holds the pin, busy, done and distance
   // values that each accepted tick must produce, oldest first.
   class ranging_tracker;
      phase_type         phase;
      logic [TICK_W-1:0] ticks;
      logic [TICK_W-1:0] echo_len;
      logic [3:0]        reading;
      logic [SUM_W-1:0]  cm_sum;
      logic [CM_W-1:0]   cm_min;
      logic [CM_W-1:0]   cm_max;
      logic [DIST_W-1:0] distance;
      logic [TRIG_W-1:0] trig_len;
      logic [TICK_W-1:0] gap_len;
      rsp_item_type      due_outputs[$];
      int                faults;

      function new();
         phase    = PH_IDLE;
         ticks    = '0;
         echo_len = '0;
         reading  = '0;
         cm_sum   = '0;
         cm_min   = '1;
         cm_max   = '0;
         distance = '0;
         trig_len = TRIGGER_TICKS_RST;
         gap_len  = GAP_TICKS_RST;
         faults   = 0;
      endfunction

      function void set_regs(logic [TRIG_W-1:0] trig, logic [TICK_W-1:0] gap);
         trig_len = trig;
         gap_len  = gap;
      endfunction

      function void advance_tick(req_item_type t);
         logic [CM_W-1:0] cm;
         int              drop;
         int              rest;
         int              mean;
         logic            stored;
         rsp_item_type    out;
         stored = 1'b0;
         case (phase)
            PH_IDLE: begin
               if (t.start_req) begin
                  reading  = '0;
                  cm_sum   = '0;
                  cm_min   = '1;
                  cm_max   = '0;
                  echo_len = '0;
                  phase    = PH_TRIG;
                  ticks    = TICK_W'(1);
               end
            end
            PH_TRIG: begin
               // a zero length still gives one trigger tick
               if (ticks >= trig_len) begin
                  phase = PH_WAIT;
                  ticks = '0;
               end else begin
                  ticks = ticks + 1'b1;
               end
            end
            PH_WAIT: begin
               if (t.echo) begin
                  phase    = PH_MEAS;
                  echo_len = TICK_W'(1);
               end
            end
            PH_MEAS: begin
               if (t.echo) begin
                  if (echo_len != '1) echo_len = echo_len + 1'b1;
               end else begin
                  cm     = CM_W'(echo_len / 16'd58);
                  cm_sum = cm_sum + cm;
                  if (cm < cm_min) cm_min = cm;
                  if (cm > cm_max) cm_max = cm;
                  ticks = '0;
                  if (int'(reading) + 1 >= SET_SIZE) begin
                     reading = '0;
                     phase   = PH_GAPL;
                  end else begin
                     reading = reading + 1'b1;
                     phase   = PH_GAP;
                  end
               end
            end
            PH_GAP, PH_GAPL: begin
               if (ticks >= gap_len) begin
                  if (phase == PH_GAPL) begin
                     drop = int'(cm_min) + int'(cm_max);
                     rest = (int'(cm_sum) >= drop) ? int'(cm_sum) - drop : 0;
                     mean = rest * 16 / ((SET_SIZE > 2) ? SET_SIZE - 2 : 1);
                     if (mean > 32'h7FFF) mean = 32'h7FFF;
                     distance = DIST_W'(mean);
                     phase    = PH_IDLE;
                     ticks    = '0;
                     stored   = 1'b1;
                  end else begin
                     phase = PH_TRIG;
                     ticks = TICK_W'(1);
                  end
               end else begin
                  ticks = ticks + 1'b1;
               end
            end
            default: begin
               phase = PH_IDLE;
               ticks = '0;
            end
         endcase
         out.trigger_out  = (phase == PH_TRIG);
         out.busy_res     = (phase != PH_IDLE);
         out.done_res     = stored;
         out.distance_x16 = distance;
         due_outputs.push_back(out);
      endfunction

      function void compare_output(rsp_item_type got);
         rsp_item_type want;
         if (due_outputs.size() == 0) begin
            if (faults < 10)
               $display("result item with no tick waiting: trig %0b busy %0b done %0b dist %0d",
                        got.trigger_out, got.busy_res, got.done_res, got.distance_x16);
            faults++;
            return;
         end
         want = due_outputs.pop_front();
         if (got.trigger_out !== want.trigger_out || got.busy_res !== want.busy_res ||
             got.done_res !== want.done_res || got.distance_x16 !== want.distance_x16) begin
            if (faults < 10)
               $display("result mismatch: expected trig %0b busy %0b done %0b dist %0d, %s",
                        want.trigger_out, want.busy_res, want.done_res, want.distance_x16,
                        $sformatf("got trig %0b busy %0b done %0b dist %0d", got.trigger_out,
                                  got.busy_res, got.done_res, got.distance_x16));
            faults++;
         end
      endfunction
   endclass

   ranging_tracker ranger = new();

   // Echo source: behaves like a sensor so that every set runs to its end.
   int   wait_left   = 0;
   int   high_left   = 0;
   bit   armed       = 1'b0;
   int   width_plan[$];
   bit   start_hold  = 1'b0;
   int   start_pct   = 100;
   bit   allow_start = 1'b0;
   bit   req_idle    = 1'b1;
   bit   rsp_idle    = 1'b1;

   // 8-unit clock period
   initial begin
      forever #4 clock = ~clock;
   end

   // Pick an echo length in ticks: mostly short, often right on a centimetre
   // boundary, now and then a few centimetres long.
   function automatic int pick_width();
      int r;
      r = $urandom_range(99);
      if (r < 50) return $urandom_range(1, 60);
      if (r < 80) return 58 * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
      return $urandom_range(61, 180);
   endfunction

   // Build the next tick from the tracked phase. Outside the echo window the
   // echo pin carries noise, which the block must ignore; starts while busy are
   // noise too.
   function automatic req_item_type next_tick();
      req_item_type it;
      int           w;
      if (ranger.phase == PH_IDLE)
         it.start_req = allow_start && ($urandom_range(99) < start_pct);
      else
         it.start_req = start_hold || ($urandom_range(99) < 20);
      it.echo = ($urandom_range(99) < 30);
      case (ranger.phase)
         PH_TRIG: begin
            // arm the next reading once per trigger pulse
            if (!armed) begin
               w = (width_plan.size() != 0) ? width_plan.pop_front() : pick_width();
               high_left = w - 1;
               wait_left = $urandom_range(0, 6);
               armed     = 1'b1;
            end
         end
         PH_WAIT: begin
            it.echo = (wait_left == 0);
            if (wait_left > 0) wait_left--;
         end
         PH_MEAS: begin
            it.echo = (high_left > 0);
            if (high_left > 0) high_left--;
            else armed = 1'b0;
         end
         default: ;
      endcase
      return it;
   endfunction

   // Offer one item, idling first at random, and hold it until accepted.
   // Returns on the edge that accepts the item.
   task automatic send_item(req_item_type it);
      if (req_idle) begin
         while ($urandom_range(99) < 30) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_item  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ranger.advance_tick(it);
   endtask

   // Drive count ticks with starts allowed, then carry on without new starts
   // until the running set has stored its result, and drop valid.
   task automatic run_ticks(int count);
      allow_start = 1'b1;
      repeat (count) send_item(next_tick());
      allow_start = 1'b0;
      while (ranger.phase != PH_IDLE) send_item(next_tick());
      req_valid <= 1'b0;
   endtask

   // Hold the sender until every expected result item is back, then let the
   // pipeline settle.
   task automatic drain();
      do @(posedge clock); while (ranger.due_outputs.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // Write the trigger register and then the gap register; call only on an edge with the
   // block idle and nothing in flight.
   task automatic configure(logic [TRIG_W-1:0] trig, logic [TICK_W-1:0] gap);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TRIGGER_TICKS;
      csr_wdata <= CSR_DATA_W'(trig);
      @(posedge clock);
      csr_index <= CSR_GAP_TICKS;
      csr_wdata <= gap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ranger.set_regs(trig, gap);
   endtask

   // Result side: check each accepted item, then stall at random.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) ranger.compare_output(rsp_item);
         rsp_ready <= !reset && (!rsp_idle || $urandom_range(99) >= 30);
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      int seg;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle ticks straight after reset: outputs must show the reset state,
      // whatever the echo pin does.
      send_item(req_item_type'{start_req: 1'b0, echo: 1'b0});
      send_item(req_item_type'{start_req: 1'b0, echo: 1'b1});
      req_valid <= 1'b0;
      drain();

      // Zero trigger length and zero gap; readings either side of the first
      // centimetre boundaries; start held high all through the set, the store
      // tick included, where it must be ignored.
      configure(8'd0, 16'd0);
      start_hold = 1'b1;
      start_pct  = 100;
      width_plan = '{57, 58, 116, 1, 117};
      run_ticks(1);
      start_hold = 1'b0;
      drain();

      // Longer trigger and gap, run without idling on either side.
      configure(8'd20, 16'd24);
      req_idle   = 1'b0;
      rsp_idle   = 1'b0;
      width_plan = '{1, 60, 30, 59, 5};
      run_ticks(1);
      drain();

      // Random sets under small settings, with idling on both sides.
      start_pct = 40;
      req_idle  = 1'b1;
      rsp_idle  = 1'b1;
      for (seg = 0; seg < 2; seg++) begin
         configure(8'($urandom_range(1, 8)), 16'($urandom_range(0, 12)));
         run_ticks(200);
         drain();
      end

      repeat (8) @(posedge clock);
      if (ranger.faults == 0 && ranger.due_outputs.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: ultrasonic_range_trimmed_mean_top.f
+incdir+sv
sv/urtm_pkg.sv
sv/urtm_mean.sv
sv/urtm_core.sv
sv/ultrasonic_range_trimmed_mean_top.sv
verif/tb_ultrasonic_range_trimmed_mean_top.sv
